FILE: hw/rtl/sha1_message_digest_assert.svh
// assertion macros for the sha1 digest rtl, used by sha1md_ctrl
// expects aclk and aresetn in the scope of each use
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// condition holds in the same cycle
`define SHA1MD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sha1md same-cycle check failed");

// condition holds in the next cycle
`define SHA1MD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sha1md next-cycle check failed");

`endif

FILE: hw/rtl/sha1md_pkg.sv
// types, constants and round functions for the sha1 digest block
// no dependencies; used by sha1md_ctrl, sha1md_dp and the top level
package sha1md_pkg;

    localparam int WORD_W      = 32;
    localparam int LEN_W       = 61;
    localparam int DIGEST_N    = 5;

    localparam logic [31:0] CHAIN_INIT [DIGEST_N] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };
    localparam logic [31:0] MARK_WORD  = 32'h80000000;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;

    localparam logic [3:0] FILL_LAST   = 4'd15;
    localparam logic [3:0] FILL_LEN    = 4'd14;
    localparam logic [6:0] ROUND_LAST  = 7'd79;
    localparam logic [6:0] ROUND_PH1   = 7'd20;
    localparam logic [6:0] ROUND_PH2   = 7'd40;
    localparam logic [6:0] ROUND_PH3   = 7'd60;
    localparam logic [2:0] OUT_LAST    = 3'd4;
    localparam logic [2:0] BYTES_FULL  = 3'd4;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    // padding sequence after the final item
    typedef enum logic [1:0] {
        PS_TAIL,
        PS_MARK,
        PS_ZERO,
        PS_LEN_LO
    } pad_step_t;

    // source of a word shifted into the block buffer
    typedef enum logic [2:0] {
        SRC_INPUT,
        SRC_TAIL,
        SRC_TAIL_PAD,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } word_src_t;

    // round groups of twenty
    typedef enum logic [1:0] {
        PH_CHOOSE,
        PH_PARITY_A,
        PH_MAJORITY,
        PH_PARITY_B
    } round_phase_t;

    typedef struct packed {
        logic         accept;
        logic         push;
        word_src_t    word_src;
        logic         wv_load;
        logic         round_en;
        round_phase_t phase;
        logic         chain_add;
        logic         chain_reload;
        logic [2:0]   out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic tail_full;
    } dp_status_t;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        return {x[30:0], x[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] x);
        return {x[1:0], x[31:2]};
    endfunction

    function automatic logic [31:0] round_f(input round_phase_t ph, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (ph)
            PH_CHOOSE:   f = ((c ^ d) & b) ^ d;
            PH_MAJORITY: f = (b & c) | (b & d) | (c & d);
            default:     f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] round_k(input round_phase_t ph);
        logic [31:0] k;
        case (ph)
            PH_CHOOSE:   k = 32'h5A827999;
            PH_PARITY_A: k = 32'h6ED9EBA1;
            PH_MAJORITY: k = 32'h8F1BBCDC;
            default:     k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

    // partial final word: keep the valid bytes, then the 0x80 marker
    function automatic logic [31:0] pad_word(input logic [31:0] data, input logic [1:0] cnt);
        logic [31:0] w;
        case (cnt)
            2'd0:    w = {PAD_BYTE, 24'h000000};
            2'd1:    w = {data[31:24], PAD_BYTE, 16'h0000};
            2'd2:    w = {data[31:16], PAD_BYTE, 8'h00};
            default: w = {data[31:8], PAD_BYTE};
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/sha1_message_digest.sv
// top level of the sha1 message digest block
// instantiates sha1md_ctrl and sha1md_dp; depends on sha1md_pkg
//
// SHA-1 over a byte message sent as 32-bit big-endian words (first byte in bits
// 31..24); only the item with s_last_item set may carry fewer than four bytes.
// Words are taken back to back within a block. Every sixteenth word starts a
// compression that uses a single round unit, one round per cycle: 80 rounds and
// then a fold into the chain value, and s_ready stays low until the fold is done.
// After the final item the padding words go into the buffer one a cycle between
// compressions (up to 16, more when an extra block is needed), each full block is
// again compressed, and then the five digest words come out on m_* as five items,
// index 0 first, at one per cycle while m_ready stays high. No input item is
// taken until the fifth digest word is accepted; the next message then starts
// from the initial chain value. The bit length wraps modulo 2^64.
module sha1_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import sha1md_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // control
    sha1md_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_last_item  (s_last_item),
        .s_ready      (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word_index (m_word_index),
        .m_last_word  (m_last_word),
        .cmd          (cmd),
        .status       (status)
    );

    // datapath
    sha1md_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_data_word   (s_data_word),
        .s_byte_count  (s_byte_count),
        .s_last_item   (s_last_item),
        .cmd           (cmd),
        .status        (status),
        .m_digest_word (m_digest_word)
    );

endmodule

FILE: hw/rtl/sha1md_dp.sv
// datapath of the sha1 digest: block buffer / schedule shift line, round unit,
// chain value, message length and tail capture; depends on sha1md_pkg
module sha1md_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [31:0]          s_data_word,
    input  logic [2:0]           s_byte_count,
    input  logic                 s_last_item,
    input  sha1md_pkg::dp_cmd_t  cmd,
    output sha1md_pkg::dp_status_t status,
    output logic [31:0]          m_digest_word
);
    import sha1md_pkg::*;

    logic [31:0]      sched_reg  [16];
    logic [31:0]      sched_next [16];
    logic [31:0]      wv_reg     [DIGEST_N];
    logic [31:0]      wv_next    [DIGEST_N];
    logic [31:0]      chain_reg  [DIGEST_N];
    logic [31:0]      chain_next [DIGEST_N];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [31:0]      tail_word_reg;
    logic [31:0]      tail_word_next;
    logic [2:0]       tail_cnt_reg;
    logic [2:0]       tail_cnt_next;

    logic [31:0]      push_word;
    logic [31:0]      sched_word;
    logic [31:0]      temp_word;
    logic [2:0]       eff_cnt;
    logic [2:0]       sat_cnt;

    // word pushed into the block buffer
    always_comb begin
        case (cmd.word_src)
            SRC_INPUT:    push_word = s_data_word;
            SRC_TAIL:     push_word = tail_word_reg;
            SRC_TAIL_PAD: push_word = pad_word(tail_word_reg, tail_cnt_reg[1:0]);
            SRC_MARK:     push_word = MARK_WORD;
            SRC_LEN_HI:   push_word = len_reg[60:29];
            SRC_LEN_LO:   push_word = {len_reg[28:0], 3'b000};
            default:      push_word = '0;
        endcase
    end

    // message schedule word and round sum
    assign sched_word = rotl1(sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0]);
    assign temp_word  = rotl5(wv_reg[0]) + round_f(cmd.phase, wv_reg[1], wv_reg[2], wv_reg[3])
                        + wv_reg[4] + sched_reg[0] + round_k(cmd.phase);

    // shift line: filled by pushes, then walked by the schedule during rounds
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sched_next[i] = sched_reg[i];
        end
        if (cmd.push || cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                sched_next[i] = sched_reg[i+1];
            end
            sched_next[15] = cmd.round_en ? sched_word : push_word;
        end
    end

    // working variables a..e
    always_comb begin
        for (int i = 0; i < DIGEST_N; i++) begin
            wv_next[i] = wv_reg[i];
        end
        if (cmd.wv_load) begin
            for (int i = 0; i < DIGEST_N; i++) begin
                wv_next[i] = chain_reg[i];
            end
        end else if (cmd.round_en) begin
            wv_next[0] = temp_word;
            wv_next[1] = wv_reg[0];
            wv_next[2] = rotl30(wv_reg[1]);
            wv_next[3] = wv_reg[2];
            wv_next[4] = wv_reg[3];
        end
    end

    // chain value update and reload
    always_comb begin
        for (int i = 0; i < DIGEST_N; i++) begin
            chain_next[i] = chain_reg[i];
            if (cmd.chain_add) begin
                chain_next[i] = chain_reg[i] + wv_reg[i];
            end else if (cmd.chain_reload) begin
                chain_next[i] = CHAIN_INIT[i];
            end
        end
    end

    // byte length and tail capture
    assign sat_cnt = (s_byte_count > BYTES_FULL) ? BYTES_FULL : s_byte_count;
    assign eff_cnt = s_last_item ? sat_cnt : BYTES_FULL;

    always_comb begin
        len_next       = len_reg;
        tail_word_next = tail_word_reg;
        tail_cnt_next  = tail_cnt_reg;
        if (cmd.chain_reload) begin
            len_next = '0;
        end else if (cmd.accept) begin
            len_next = len_reg + {{(LEN_W-3){1'b0}}, eff_cnt};
        end
        if (cmd.accept && s_last_item) begin
            tail_word_next = s_data_word;
            tail_cnt_next  = sat_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            for (int i = 0; i < DIGEST_N; i++) begin
                chain_reg[i] <= CHAIN_INIT[i];
            end
        end else begin
            len_reg <= len_next;
            for (int i = 0; i < DIGEST_N; i++) begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) begin
            sched_reg[i] <= sched_next[i];
        end
        for (int i = 0; i < DIGEST_N; i++) begin
            wv_reg[i] <= wv_next[i];
        end
        tail_word_reg <= tail_word_next;
        tail_cnt_reg  <= tail_cnt_next;
    end

    assign status.tail_full = (tail_cnt_reg == BYTES_FULL);

    // digest word select
    always_comb begin
        case (cmd.out_sel)
            3'd0:    m_digest_word = chain_reg[0];
            3'd1:    m_digest_word = chain_reg[1];
            3'd2:    m_digest_word = chain_reg[2];
            3'd3:    m_digest_word = chain_reg[3];
            default: m_digest_word = chain_reg[4];
        endcase
    end

endmodule

FILE: hw/rtl/sha1md_ctrl.sv
// controller of the sha1 digest: item handshake, block fill count, padding
// sequence, round counter and digest output; depends on sha1md_pkg and the assert header
`include "sha1_message_digest_assert.svh"

module sha1md_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_last_item,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_word_index,
    output logic                   m_last_word,
    output sha1md_pkg::dp_cmd_t    cmd,
    input  sha1md_pkg::dp_status_t status
);
    import sha1md_pkg::*;

    state_t     state_reg,    state_next;
    pad_step_t  step_reg,     step_next;
    logic [3:0] fill_reg,     fill_next;
    logic [6:0] round_reg,    round_next;
    logic [2:0] out_idx_reg,  out_idx_next;
    logic       final_reg,    final_next;
    logic       resume_reg,   resume_next;

    // next state
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        fill_next    = fill_reg;
        round_next   = round_reg;
        out_idx_next = out_idx_reg;
        final_next   = final_reg;
        resume_next  = resume_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_last_item) begin
                        state_next = ST_PAD;
                        step_next  = PS_TAIL;
                    end else begin
                        fill_next = fill_reg + 4'd1;
                        if (fill_reg == FILL_LAST) begin
                            state_next  = ST_ROUND;
                            resume_next = 1'b0;
                            final_next  = 1'b0;
                        end
                    end
                end
            end
            ST_PAD: begin
                fill_next = fill_reg + 4'd1;
                case (step_reg)
                    PS_TAIL:   step_next = status.tail_full ? PS_MARK : PS_ZERO;
                    PS_MARK:   step_next = PS_ZERO;
                    PS_ZERO:   step_next = (fill_reg == FILL_LEN) ? PS_LEN_LO : PS_ZERO;
                    PS_LEN_LO: step_next = PS_LEN_LO;
                    default:   step_next = PS_TAIL;
                endcase
                if (fill_reg == FILL_LAST) begin
                    state_next  = ST_ROUND;
                    resume_next = 1'b1;
                    final_next  = (step_reg == PS_LEN_LO);
                end
            end
            ST_ROUND: begin
                round_next = round_reg + 7'd1;
                if (round_reg == ROUND_LAST) begin
                    round_next = '0;
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (final_reg) begin
                    state_next = ST_OUT;
                end else if (resume_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (out_idx_reg == OUT_LAST) begin
                        out_idx_next = '0;
                        final_next   = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        cmd         = '0;
        cmd.out_sel = out_idx_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.accept   = s_valid;
                cmd.push     = s_valid && !s_last_item;
                cmd.word_src = SRC_INPUT;
                cmd.wv_load  = s_valid && !s_last_item && (fill_reg == FILL_LAST);
            end
            ST_PAD: begin
                cmd.push    = 1'b1;
                cmd.wv_load = (fill_reg == FILL_LAST);
                case (step_reg)
                    PS_TAIL:   cmd.word_src = status.tail_full ? SRC_TAIL : SRC_TAIL_PAD;
                    PS_MARK:   cmd.word_src = SRC_MARK;
                    PS_ZERO:   cmd.word_src = (fill_reg == FILL_LEN) ? SRC_LEN_HI : SRC_ZERO;
                    PS_LEN_LO: cmd.word_src = SRC_LEN_LO;
                    default:   cmd.word_src = SRC_ZERO;
                endcase
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                if (round_reg < ROUND_PH1) begin
                    cmd.phase = PH_CHOOSE;
                end else if (round_reg < ROUND_PH2) begin
                    cmd.phase = PH_PARITY_A;
                end else if (round_reg < ROUND_PH3) begin
                    cmd.phase = PH_MAJORITY;
                end else begin
                    cmd.phase = PH_PARITY_B;
                end
            end
            ST_ADD: begin
                cmd.chain_add = 1'b1;
            end
            ST_OUT: begin
                m_valid          = 1'b1;
                cmd.chain_reload = m_ready && (out_idx_reg == OUT_LAST);
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign m_word_index = out_idx_reg;
    assign m_last_word  = (out_idx_reg == OUT_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= PS_TAIL;
            fill_reg    <= '0;
            round_reg   <= '0;
            out_idx_reg <= '0;
            final_reg   <= 1'b0;
            resume_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            fill_reg    <= fill_next;
            round_reg   <= round_next;
            out_idx_reg <= out_idx_next;
            final_reg   <= final_next;
            resume_reg  <= resume_next;
        end
    end

    // a compression always starts from round zero with an empty buffer count
    `SHA1MD_ASSERT_NEXT(a_block_start, cmd.wv_load, (state_reg == ST_ROUND) && (round_reg == '0) && (fill_reg == '0))
    // no item is taken while a digest is on offer
    `SHA1MD_ASSERT_SAME(a_ready_excl, m_valid, !s_ready)
    // after the fifth digest word the block is back to an empty message
    `SHA1MD_ASSERT_NEXT(a_msg_done, m_valid && m_ready && m_last_word, s_ready && (fill_reg == '0) && !final_reg)
    // digest index stays within the five words
    `SHA1MD_ASSERT_SAME(a_index_range, m_valid, out_idx_reg <= OUT_LAST)

endmodule

FILE: dv/sha1md_digest_checker.sv
// digest checker for the sha1 message digest block: watches both channels,
// hashes every accepted message item itself and compares each digest word
// no dependencies beyond the port list of sha1_message_digest
module sha1md_digest_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last_item,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_digest_word,
    input  logic [2:0]  m_word_index,
    input  logic        m_last_word,
    output int          error_count,
    output int          expected_left,
    output int          words_checked
);

    localparam logic [31:0] H_START [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };
    localparam logic [31:0] K_CHOOSE   = 32'h5A827999;
    localparam logic [31:0] K_PARITY_A = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
    localparam logic [31:0] K_PARITY_B = 32'hCA62C1D6;
    localparam logic [31:0] END_MARK   = 32'h80000000;
    localparam logic [31:0] MARK_BYTE  = 32'h00000080;
    localparam logic [2:0]  WORD_BYTES = 3'd4;
    localparam int          LEN_SLOT   = 14;
    localparam int          BLOCK_WORDS = 16;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_entry_t;

    // running hash state of the message in flight
    logic [31:0]   chain [5];
    logic [31:0]   block_buf [16];
    int            fill;
    logic [60:0]   msg_bytes;
    digest_entry_t digest_q [$];

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // 80 rounds over the buffered block, folded into the chain
    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int s;
        w = block_buf;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < 80; r++) begin
            s = r % 16;
            if (r >= 16)
                w[s] = rol(w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s], 1);
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_CHOOSE;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_PARITY_A;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJORITY;
            end else begin
                f = b ^ c ^ d;
                k = K_PARITY_B;
            end
            t = rol(a, 5) + f + e + w[s] + k;
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endtask

    task automatic load_block_word(input logic [31:0] w);
        block_buf[fill] = w;
        fill++;
        if (fill == BLOCK_WORDS) begin
            compress_block();
            fill = 0;
        end
    endtask

    // one message item; a final item pads, queues five digest words and restarts
    task automatic absorb_item(input logic [31:0] data, input logic [2:0] cnt,
                               input logic fin);
        logic [2:0]    n;
        logic [31:0]   keep;
        logic [63:0]   bit_len;
        digest_entry_t ent;
        if (!fin) begin
            msg_bytes = msg_bytes + 61'd4;
            load_block_word(data);
            return;
        end
        n = (cnt > WORD_BYTES) ? WORD_BYTES : cnt;
        msg_bytes = msg_bytes + 61'(n);
        if (n == WORD_BYTES) begin
            load_block_word(data);
            load_block_word(END_MARK);
        end else begin
            keep = (n == 0) ? 32'h0 : ~(32'hffffffff >> (8 * n));
            load_block_word((data & keep) | (MARK_BYTE << (24 - 8 * n)));
        end
        // length does not fit behind the marker: zero out an extra block
        if (fill > LEN_SLOT)
            while (fill != 0)
                load_block_word(32'h0);
        while (fill < LEN_SLOT)
            load_block_word(32'h0);
        bit_len = {msg_bytes, 3'b000};
        load_block_word(bit_len[63:32]);
        load_block_word(bit_len[31:0]);
        for (int i = 0; i < 5; i++) begin
            ent.word  = chain[i];
            ent.index = 3'(i);
            ent.last  = (i == 4);
            digest_q.push_back(ent);
        end
        chain     = H_START;
        fill      = 0;
        msg_bytes = '0;
    endtask

    // watch both channels and compare each accepted digest word
    always @(posedge aclk) begin
        digest_entry_t want;
        if (!aresetn) begin
            chain         = H_START;
            fill          = 0;
            msg_bytes     = '0;
            digest_q.delete();
            error_count   = 0;
            words_checked = 0;
            expected_left <= 0;
        end else begin
            if (s_valid && s_ready)
                absorb_item(s_data_word, s_byte_count, s_last_item);
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest item: digest_word %h word_index %0d",
                           m_digest_word, m_word_index);
                    error_count++;
                end else begin
                    want = digest_q.pop_front();
                    words_checked++;
                    if (m_digest_word !== want.word) begin
                        $error("digest_word: expected %h, actual %h",
                               want.word, m_digest_word);
                        error_count++;
                    end
                    if (m_word_index !== want.index) begin
                        $error("word_index: expected %0d, actual %0d",
                               want.index, m_word_index);
                        error_count++;
                    end
                    if (m_last_word !== want.last) begin
                        $error("last_word: expected %0d, actual %0d",
                               want.last, m_last_word);
                        error_count++;
                    end
                end
            end
            expected_left <= digest_q.size();
        end
    end

endmodule

FILE: dv/sha1_message_digest_tb.sv
// testbench top for sha1_message_digest: clock, reset, message stimulus,
// digest sink with random stalls, watchdog and verdict
// depends on sha1_message_digest and sha1md_digest_checker
module sha1_message_digest_tb;

    localparam int HOLD_AT      = 37;
    localparam int LONG_HOLD    = 600;
    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_ITEMS = 196;
    localparam int TAIL_CYCLES  = 100;

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [31:0] s_data_word  = '0;
    logic [2:0]  s_byte_count = '0;
    logic        s_last_item  = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    int error_count;
    int expected_left;
    int words_checked;
    int items_sent;
    int messages_sent;

    sha1_message_digest dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .s_byte_count  (s_byte_count),
        .s_last_item   (s_last_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    sha1md_digest_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .s_byte_count  (s_byte_count),
        .s_last_item   (s_last_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word),
        .error_count   (error_count),
        .expected_left (expected_left),
        .words_checked (words_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // one message item; valid stays high when the next item follows at once
    task automatic send_item(input logic [31:0] data, input logic [2:0] cnt,
                             input logic fin);
        int gap;
        gap = ((items_sent / 32) % 3 == 1) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_word  <= data;
        s_byte_count <= cnt;
        s_last_item  <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (fin)
            messages_sent++;
    endtask

    // stop offering until every digest word has come back
    task automatic drain_digests();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
    endtask

    // random message; lengths cluster around the block boundary
    task automatic send_message(input int n_words);
        logic [31:0] data;
        for (int i = 0; i < n_words; i++) begin
            case ($urandom_range(0, 15))
                0:       data = 32'h0;
                1:       data = 32'hffffffff;
                default: data = $urandom();
            endcase
            send_item(data, 3'($urandom_range(0, 7)), i == n_words - 1);
        end
    endtask

    // stimulus: directed corners, then random messages
    initial begin : stimulus
        int len;
        int msg_no;
        items_sent    = 0;
        messages_sent = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one-item messages: byte counts 0 to 5 and 7, incl. saturated ones
        send_item(32'h0, 3'd0, 1'b1);
        send_item(32'hffffffff, 3'd0, 1'b1);
        send_item(32'hffffffff, 3'd1, 1'b1);
        send_item(32'h0, 3'd2, 1'b1);
        send_item(32'hffffffff, 3'd3, 1'b1);
        send_item(32'h61626300, 3'd4, 1'b1);
        send_item($urandom(), 3'd5, 1'b1);
        send_item(32'hffffffff, 3'd7, 1'b1);
        // byte count of a non-final item is ignored
        send_item(32'hffffffff, 3'd0, 1'b0);
        send_item(32'h0, 3'd6, 1'b1);
        // marker lands right before the length words
        for (int i = 0; i < 13; i++)
            send_item($urandom(), 3'd4, 1'b0);
        send_item($urandom(), 3'd2, 1'b1);
        drain_digests();

        msg_no = 0;
        while (items_sent < RANDOM_ITEMS + 24) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = $urandom_range(1, 4);
                4, 5, 6:    len = $urandom_range(13, 18);
                default:    len = $urandom_range(19, 34);
            endcase
            send_message(len);
            msg_no++;
            if (msg_no == 4)
                drain_digests();
        end
        s_valid <= 1'b0;

        // wait out the last digest, then idle before the verdict
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("sent %0d message items in %0d messages", items_sent, messages_sent);
        $display("checked %0d digest words, %0d mismatches", words_checked, error_count);
        if (error_count == 0 && expected_left == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // digest sink: random stalls, one long hold-off mid-digest
    initial begin : digest_sink
        int stall;
        int taken;
        taken = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken == HOLD_AT)
                stall = LONG_HOLD;
            else if ((taken / 20) % 3 == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    end

    // watchdog on cycles with no item moving on either channel
    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("no item moved for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sha1md_pkg.sv
hw/rtl/sha1md_dp.sv
hw/rtl/sha1md_ctrl.sv
hw/rtl/sha1_message_digest.sv
dv/sha1md_digest_checker.sv
dv/sha1_message_digest_tb.sv
